// ----- rtl/jsu_pkg.sv -----
// Package for the JSON string unescaper: phase codes, result and descriptor
// types, byte constants and the UTF-8 encoding helpers.
// Depends on nothing; every file but jsu_if imports it.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	typedef enum logic [2:0] {
		PH_PLAIN   = 3'd0,
		PH_ESC     = 3'd1,
		PH_HEX1    = 3'd2,
		PH_HIGH    = 3'd3,
		PH_HIGH_BS = 3'd4,
		PH_HEX2    = 3'd5
	} phase_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_FF  = 8'h0C;

	localparam logic [15:0] HIGH_LO  = 16'hD800;
	localparam logic [15:0] HIGH_HI  = 16'hDC00;
	localparam logic [20:0] LOW_BASE = 21'h00DC00;
	localparam logic [20:0] SUPP_BASE = 21'h010000;
	localparam logic [20:0] LIM_1B   = 21'h000080;
	localparam logic [20:0] LIM_2B   = 21'h000800;
	localparam logic [20:0] LIM_3B   = 21'h010000;
	localparam logic [7:0]  LEAD_2B  = 8'hC0;
	localparam logic [7:0]  LEAD_3B  = 8'hE0;
	localparam logic [7:0]  LEAD_4B  = 8'hF0;
	localparam logic [7:0]  CONT_B   = 8'h80;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       string_end;
		logic       bad_escape;
	} res_t;

	typedef struct packed {
		logic present;
		res_t res;
	} tail_t;

	typedef struct packed {
		res_t [3:0] res;
		logic [2:0] cnt;
	} desc_t;

	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, c[3:0]};
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r = {1'b1, c[3:0] + 4'd9};
		return r;
	endfunction

	function automatic desc_t utf8_enc(input logic [20:0] cp);
		desc_t d;
		d = '0;
		if (cp < LIM_1B) begin
			d.res[0] = '{data: cp[7:0], byte_valid: 1'b1, string_end: 1'b0, bad_escape: 1'b0};
			d.cnt = 3'd1;
		end else if (cp < LIM_2B) begin
			d.res[0] = '{LEAD_2B | {3'b0, cp[10:6]}, 1'b1, 1'b0, 1'b0};
			d.res[1] = '{CONT_B | {2'b0, cp[5:0]}, 1'b1, 1'b0, 1'b0};
			d.cnt = 3'd2;
		end else if (cp < LIM_3B) begin
			d.res[0] = '{LEAD_3B | {4'b0, cp[15:12]}, 1'b1, 1'b0, 1'b0};
			d.res[1] = '{CONT_B | {2'b0, cp[11:6]}, 1'b1, 1'b0, 1'b0};
			d.res[2] = '{CONT_B | {2'b0, cp[5:0]}, 1'b1, 1'b0, 1'b0};
			d.cnt = 3'd3;
		end else begin
			d.res[0] = '{LEAD_4B | {5'b0, cp[20:18]}, 1'b1, 1'b0, 1'b0};
			d.res[1] = '{CONT_B | {2'b0, cp[17:12]}, 1'b1, 1'b0, 1'b0};
			d.res[2] = '{CONT_B | {2'b0, cp[11:6]}, 1'b1, 1'b0, 1'b0};
			d.res[3] = '{CONT_B | {2'b0, cp[5:0]}, 1'b1, 1'b0, 1'b0};
			d.cnt = 3'd4;
		end
		return d;
	endfunction

	function automatic tail_t plain_tail(input logic [7:0] c);
		tail_t t;
		t = '0;
		if (c == CH_QUOTE) begin
			t.present = 1'b1;
			t.res.string_end = 1'b1;
		end else if (c != CH_BSLASH) begin
			t.present = 1'b1;
			t.res.data = c;
			t.res.byte_valid = 1'b1;
		end
		return t;
	endfunction

	function automatic tail_t esc_tail(input logic [7:0] c);
		tail_t t;
		t = '0;
		t.present = 1'b1;
		t.res.byte_valid = 1'b1;
		unique case (c)
			CH_N:    t.res.data = CODE_LF;
			CH_R:    t.res.data = CODE_CR;
			CH_T:    t.res.data = CODE_TAB;
			CH_B:    t.res.data = CODE_BS;
			CH_F:    t.res.data = CODE_FF;
			CH_U:    t = '0;
			default: t.res.data = c;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/jsu_if.sv -----
// Valid/ready channel interfaces for the raw byte input and the decoded
// result output. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       string_end;
	logic       bad_escape;
	logic       last;

	modport source(output valid, output out_byte, output byte_valid, output string_end,
		output bad_escape, output last, input ready);
	modport sink(input valid, input out_byte, input byte_valid, input string_end,
		input bad_escape, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/json_string_unescape_utf8.sv -----
// JSON string unescaper, top level: front end, descriptor queue, back end.
// Uses jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back.
//
// The raw channel takes one byte of a JSON string body per word, starting
// after the opening quote and including the closing quote. The dec channel
// gives the decoded results: a byte with byte_valid, a string_end word for
// the closing quote, or a bad_escape word for a non-hex digit in a \u escape.
// last marks the final result caused by one input byte; a byte may cause
// none (a backslash, a hex digit) or up to four (a UTF-8 sequence).
// Throughput: one input byte per cycle while the queue has room; the output
// side gives one result per cycle while dec is ready, so a byte with k
// results holds the back end until they are all out, and the four-entry
// descriptor queue absorbs the burst. The first result of a byte passes
// through the descriptor queue and the output register before it is on dec.
// Reset clears the escape phase and the queue; the next byte starts a body.
// When the receiver stalls, the output register holds its word, the queue
// fills, and raw.ready falls once four descriptors are waiting.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8 import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	jsu_in_if.sink    raw,
	jsu_out_if.source dec
);

	desc_t push_desc;
	desc_t head;
	logic  push;
	logic  q_ready;
	logic  pop;
	logic  head_valid;

	jsu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw),
		.q_ready (q_ready),
		.desc    (push_desc),
		.push    (push)
	);

	jsu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.ready      (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.dec        (dec)
	);

endmodule

`default_nettype wire

// ----- rtl/jsu_front.sv -----
// Front end: accepts raw bytes, tracks the escape phase and turns each
// word into a descriptor of up to four results. Uses jsu_pkg and jsu_in_if.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front import jsu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jsu_in_if.sink     raw,
	input  wire logic  q_ready,
	output desc_t      desc,
	output logic       push
);

	phase_t      phase_q, phase_d;
	logic [15:0] hex_q, hex_d;
	logic [1:0]  digits_q, digits_d;
	logic [15:0] high_q, high_d;

	logic        accept;
	logic [7:0]  c;
	logic [4:0]  hex_digit;
	logic        hex_ok;
	logic [15:0] hex_next;
	logic        last_digit;
	logic        is_high;
	logic [20:0] pair_cp;
	desc_t       high3;
	tail_t       tail;

	assign raw.ready  = q_ready;
	assign accept     = raw.valid && q_ready;
	assign c          = raw.in_byte;
	assign hex_digit  = hex_of(c);
	assign hex_ok     = hex_digit[4];
	assign hex_next   = {hex_q[11:0], hex_digit[3:0]};
	assign last_digit = (digits_q == 2'd3);
	assign is_high    = (hex_next >= HIGH_LO) && (hex_next < HIGH_HI);
	assign pair_cp    = SUPP_BASE + {1'b0, high_q[9:0], 10'b0} + {5'b0, hex_next} - LOW_BASE;
	assign high3      = utf8_enc({5'b0, high_q});

	always_comb begin
		phase_d  = phase_q;
		hex_d    = hex_q;
		digits_d = digits_q;
		high_d   = high_q;
		unique case (phase_q) inside
			PH_ESC: begin
				if (c == CH_U) begin
					phase_d  = PH_HEX1;
					hex_d    = '0;
					digits_d = '0;
				end else begin
					phase_d = PH_PLAIN;
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (!hex_ok) begin
					phase_d  = PH_PLAIN;
					hex_d    = '0;
					digits_d = '0;
					high_d   = '0;
				end else if (last_digit) begin
					hex_d    = '0;
					digits_d = '0;
					if (phase_q == PH_HEX1 && is_high) begin
						phase_d = PH_HIGH;
						high_d  = hex_next;
					end else begin
						phase_d = PH_PLAIN;
					end
				end else begin
					hex_d    = hex_next;
					digits_d = digits_q + 2'd1;
				end
			end
			PH_HIGH: begin
				phase_d = (c == CH_BSLASH) ? PH_HIGH_BS : PH_PLAIN;
			end
			PH_HIGH_BS: begin
				if (c == CH_U) begin
					phase_d  = PH_HEX2;
					hex_d    = '0;
					digits_d = '0;
				end else begin
					phase_d = PH_PLAIN;
				end
			end
			default: begin
				phase_d = (c == CH_BSLASH) ? PH_ESC : PH_PLAIN;
			end
		endcase
	end

	always_comb begin
		desc = '0;
		tail = '0;
		unique case (phase_q) inside
			PH_ESC: tail = esc_tail(c);
			PH_HEX1, PH_HEX2: begin
				if (!hex_ok) begin
					tail.present        = 1'b1;
					tail.res.bad_escape = 1'b1;
				end else if (last_digit) begin
					if (phase_q == PH_HEX2)
						desc = utf8_enc(pair_cp);
					else if (!is_high)
						desc = utf8_enc({5'b0, hex_next});
				end
			end
			PH_HIGH: begin
				if (c != CH_BSLASH) begin
					desc = high3;
					tail = plain_tail(c);
				end
			end
			PH_HIGH_BS: begin
				if (c != CH_U) begin
					desc = high3;
					tail = esc_tail(c);
				end
			end
			default: tail = plain_tail(c);
		endcase
		if (tail.present) begin
			desc.res[desc.cnt[1:0]] = tail.res;
			desc.cnt = desc.cnt + 3'd1;
		end
	end

	assign push = accept && (desc.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PLAIN;
			hex_q    <= '0;
			digits_q <= '0;
			high_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			hex_q    <= hex_d;
			digits_q <= digits_d;
			high_q   <= high_d;
		end
	end

`ifndef SYNTHESIS
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (desc.cnt <= 3'd4))
		else $error("descriptor holds more than four results");
`endif

endmodule

`default_nettype wire

// ----- rtl/jsu_queue.sv -----
// Short descriptor queue between the front and back ends, held in
// flip-flops and read at the head only. Uses jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue import jsu_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire desc_t  push_desc,
	output logic        ready,
	input  wire logic   pop,
	output logic        head_valid,
	output desc_t       head
);

	desc_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign ready      = (cnt_q != QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("write into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("read from an empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/jsu_back.sv -----
// Back end: walks the head descriptor into the output register one result
// per cycle while dec takes the words. Uses jsu_pkg and jsu_out_if.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back import jsu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire desc_t head,
	output logic       pop,
	jsu_out_if.source  dec
);

	logic       ov_q;
	logic [1:0] idx_q;
	res_t       res_q;
	logic       last_q;
	logic       load;
	logic       is_last;

	assign load    = head_valid && (!ov_q || dec.ready);
	assign is_last = ({1'b0, idx_q} + 3'd1) == head.cnt;
	assign pop     = load && is_last;

	assign dec.valid      = ov_q;
	assign dec.out_byte   = res_q.data;
	assign dec.byte_valid = res_q.byte_valid;
	assign dec.string_end = res_q.string_end;
	assign dec.bad_escape = res_q.bad_escape;
	assign dec.last       = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head.res[idx_q];
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (dec.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, idx_q} < head.cnt))
		else $error("result index beyond descriptor count");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (idx_q == 2'd0))
		else $error("result index left over with empty queue");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && dec.ready && !head_valid) |=> !ov_q)
		else $error("taken word not cleared from the output register");
`endif

endmodule

`default_nettype wire

// ----- tb/jsu_unescape_checker.sv -----
// Decode checker for the JSON string unescaper: follows the raw and dec channels,
// predicts the decoded words of every accepted byte and compares them in order.
// Depends on jsu_pkg and the jsu_in_if and jsu_out_if channel interfaces.
`timescale 1ns / 1ps

module jsu_unescape_checker import jsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	jsu_in_if    raw,
	jsu_out_if   dec,
	output int   mismatches,
	output int   pending,
	output int   bytes_taken,
	output int   words_checked,
	output int   ends_seen,
	output int   bad_seen
);

	localparam logic [7:0] DIG_0 = 8'h30;
	localparam logic [7:0] DIG_9 = 8'h39;
	localparam logic [7:0] LOW_A = 8'h61;
	localparam logic [7:0] LOW_F = 8'h66;
	localparam logic [7:0] UP_A  = 8'h41;
	localparam logic [7:0] UP_F  = 8'h46;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_end;
		logic       bad_escape;
		logic       last;
	} dec_word_t;

	phase_t      phase;
	logic [15:0] hex_acc;
	logic [1:0]  digit_cnt;
	logic [15:0] high_unit;
	dec_word_t   expected_words[$];

	function automatic int digit_of(input logic [7:0] c);
		if (c >= DIG_0 && c <= DIG_9)
			return int'(c - DIG_0);
		if (c >= LOW_A && c <= LOW_F)
			return int'(c - LOW_A) + 10;
		if (c >= UP_A && c <= UP_F)
			return int'(c - UP_A) + 10;
		return -1;
	endfunction

	function automatic void put_word(input logic [7:0] b, input logic v, input logic e,
			input logic bad);
		dec_word_t w;
		w = '{out_byte: b, byte_valid: v, string_end: e, bad_escape: bad, last: 1'b0};
		expected_words.insert(expected_words.size(), w);
	endfunction

	function automatic void put_utf8(input logic [31:0] cp);
		if (cp < LIM_1B) begin
			put_word(cp[7:0], 1'b1, 1'b0, 1'b0);
		end else if (cp < LIM_2B) begin
			put_word(LEAD_2B | {3'b000, cp[10:6]}, 1'b1, 1'b0, 1'b0);
			put_word(CONT_B | {2'b00, cp[5:0]}, 1'b1, 1'b0, 1'b0);
		end else if (cp < LIM_3B) begin
			put_word(LEAD_3B | {4'b0000, cp[15:12]}, 1'b1, 1'b0, 1'b0);
			put_word(CONT_B | {2'b00, cp[11:6]}, 1'b1, 1'b0, 1'b0);
			put_word(CONT_B | {2'b00, cp[5:0]}, 1'b1, 1'b0, 1'b0);
		end else begin
			put_word(LEAD_4B | {5'b00000, cp[20:18]}, 1'b1, 1'b0, 1'b0);
			put_word(CONT_B | {2'b00, cp[17:12]}, 1'b1, 1'b0, 1'b0);
			put_word(CONT_B | {2'b00, cp[11:6]}, 1'b1, 1'b0, 1'b0);
			put_word(CONT_B | {2'b00, cp[5:0]}, 1'b1, 1'b0, 1'b0);
		end
	endfunction

	function automatic void take_plain(input logic [7:0] c);
		phase = PH_PLAIN;
		if (c == CH_QUOTE) begin
			put_word(8'h00, 1'b0, 1'b1, 1'b0);
		end else if (c == CH_BSLASH) begin
			phase = PH_ESC;
		end else begin
			put_word(c, 1'b1, 1'b0, 1'b0);
		end
	endfunction

	function automatic void take_escaped(input logic [7:0] c);
		phase = PH_PLAIN;
		case (c)
			CH_N: put_word(CODE_LF, 1'b1, 1'b0, 1'b0);
			CH_R: put_word(CODE_CR, 1'b1, 1'b0, 1'b0);
			CH_T: put_word(CODE_TAB, 1'b1, 1'b0, 1'b0);
			CH_B: put_word(CODE_BS, 1'b1, 1'b0, 1'b0);
			CH_F: put_word(CODE_FF, 1'b1, 1'b0, 1'b0);
			CH_U: begin
				phase = PH_HEX1;
				hex_acc = '0;
				digit_cnt = '0;
			end
			default: put_word(c, 1'b1, 1'b0, 1'b0);
		endcase
	endfunction

	function automatic void take_hex(input logic [7:0] c, input logic second);
		int          d;
		logic [31:0] hi32;
		logic [31:0] lo32;
		logic [31:0] cp;
		d = digit_of(c);
		if (d < 0) begin
			phase = PH_PLAIN;
			hex_acc = '0;
			digit_cnt = '0;
			high_unit = '0;
			put_word(8'h00, 1'b0, 1'b0, 1'b1);
			return;
		end
		hex_acc = {hex_acc[11:0], d[3:0]};
		if (digit_cnt != 2'd3) begin
			digit_cnt = digit_cnt + 2'd1;
			return;
		end
		digit_cnt = '0;
		if (!second) begin
			if (hex_acc >= HIGH_LO && hex_acc < HIGH_HI) begin
				high_unit = hex_acc;
				phase = PH_HIGH;
			end else begin
				put_utf8({16'h0000, hex_acc});
				phase = PH_PLAIN;
			end
		end else begin
			hi32 = {16'h0000, high_unit};
			lo32 = {16'h0000, hex_acc};
			cp = 32'(SUPP_BASE) + ((hi32 - 32'(HIGH_LO)) << 10) + (lo32 - 32'(LOW_BASE));
			put_utf8(cp);
			phase = PH_PLAIN;
		end
		hex_acc = '0;
	endfunction

	function automatic void decode_byte(input logic [7:0] c);
		int n;
		n = expected_words.size();
		case (phase)
			PH_ESC:  take_escaped(c);
			PH_HEX1: take_hex(c, 1'b0);
			PH_HIGH: begin
				if (c == CH_BSLASH) begin
					phase = PH_HIGH_BS;
				end else begin
					put_utf8({16'h0000, high_unit});
					take_plain(c);
				end
			end
			PH_HIGH_BS: begin
				if (c == CH_U) begin
					phase = PH_HEX2;
					hex_acc = '0;
					digit_cnt = '0;
				end else begin
					put_utf8({16'h0000, high_unit});
					take_escaped(c);
				end
			end
			PH_HEX2: take_hex(c, 1'b1);
			default: take_plain(c);
		endcase
		if (expected_words.size() > n)
			expected_words[expected_words.size() - 1].last = 1'b1;
	endfunction

	function automatic string show(input dec_word_t w);
		return $sformatf("out_byte=%02h byte_valid=%0b string_end=%0b bad_escape=%0b last=%0b",
			w.out_byte, w.byte_valid, w.string_end, w.bad_escape, w.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dec_word_t got;
		dec_word_t want;
		if (!arst_n) begin
			phase = PH_PLAIN;
			hex_acc = '0;
			digit_cnt = '0;
			high_unit = '0;
			expected_words.delete();
			mismatches = 0;
			bytes_taken = 0;
			words_checked = 0;
			ends_seen = 0;
			bad_seen = 0;
			pending <= 0;
		end else begin
			if (raw.valid && raw.ready) begin
				decode_byte(raw.in_byte);
				bytes_taken++;
			end
			if (dec.valid && dec.ready) begin
				got = '{dec.out_byte, dec.byte_valid, dec.string_end, dec.bad_escape, dec.last};
				words_checked++;
				if (got.string_end)
					ends_seen++;
				if (got.bad_escape)
					bad_seen++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected dec word: %s", $realtime, show(got));
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: dec word %0d\n  expected %s\n  actual   %s",
								$realtime, words_checked, show(want), show(got));
					end
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule

// ----- tb/json_string_unescape_utf8_tb.sv -----
// Testbench top for json_string_unescape_utf8: drives JSON string body bytes,
// directed escapes first, then random bytes and escapes, under four pacing modes.
// Depends on jsu_pkg, the channel interfaces, the block and jsu_unescape_checker.
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
	import jsu_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jsu_in_if  raw_ch();
	jsu_out_if dec_ch();

	int mismatches;
	int pending;
	int bytes_taken;
	int words_checked;
	int ends_seen;
	int bad_seen;

	int sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int send_pct[4] = '{0, 81, 0, 7};
	int recv_pct[4] = '{0, 0, 81, 7};

	string      hex_low = "0123456789abcdef";
	string      hex_up  = "0123456789ABCDEF";
	logic [7:0] simple_esc[5] = '{CH_N, CH_R, CH_T, CH_B, CH_F};

	always #5 clk = ~clk;

	json_string_unescape_utf8 DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.raw   (raw_ch),
		.dec   (dec_ch)
	);

	jsu_unescape_checker decode_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.raw          (raw_ch),
		.dec          (dec_ch),
		.mismatches   (mismatches),
		.pending      (pending),
		.bytes_taken  (bytes_taken),
		.words_checked(words_checked),
		.ends_seen    (ends_seen),
		.bad_seen     (bad_seen)
	);

	always @(posedge clk) begin
		dec_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(255, 0));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		return $urandom_range(1, 0) ? hex_up[d] : hex_low[d];
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		b = any_byte();
		for (int i = 0; i < 16; i++) begin
			if (b == hex_low[i] || b == hex_up[i])
				return b ^ 8'h80;
		end
		return b;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			raw_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		raw_ch.valid <= 1'b1;
		raw_ch.in_byte <= b;
		do @(posedge clk); while (!raw_ch.ready);
		sent++;
	endtask

	task automatic send_unit(input logic [15:0] v);
		send_byte(CH_BSLASH);
		send_byte(CH_U);
		for (int i = 3; i >= 0; i--)
			send_byte(hex_char(v[i * 4 +: 4]));
	endtask

	task automatic send_bad_unit();
		int n;
		n = $urandom_range(3, 0);
		send_byte(CH_BSLASH);
		send_byte(CH_U);
		repeat (n) send_byte(hex_char(4'($urandom_range(15, 0))));
		send_byte(non_hex_byte());
	endtask

	task automatic wait_drained();
		raw_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_token();
		int         k;
		int         j;
		logic [7:0] b;
		logic [15:0] v;
		k = $urandom_range(99, 0);
		if (k < 30) begin
			send_byte(any_byte());
		end else if (k < 45) begin
			send_byte(CH_BSLASH);
			if ($urandom_range(1, 0)) begin
				send_byte(simple_esc[$urandom_range(4, 0)]);
			end else begin
				b = any_byte();
				if (b == CH_U)
					b = CH_BSLASH;
				send_byte(b);
			end
		end else if (k < 75) begin
			j = $urandom_range(5, 0);
			case (j)
				0: v = 16'($urandom_range(16'h007F, 0));
				1: v = 16'($urandom_range(16'h07FF, 16'h0080));
				2: begin
					if ($urandom_range(1, 0))
						v = 16'($urandom_range(16'hD7FF, 16'h0800));
					else
						v = 16'($urandom_range(16'hFFFF, 16'hE000));
				end
				3: v = 16'($urandom_range(16'hDFFF, 16'hDC00));
				default: v = 16'($urandom_range(16'hDBFF, 16'hD800));
			endcase
			send_unit(v);
			if (j >= 4) begin
				j = $urandom_range(9, 0);
				if (j <= 4) begin
					send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)));
				end else if (j == 5) begin
					send_unit(16'($urandom_range(16'hFFFF, 0)));
				end else if (j == 6) begin
					send_byte(any_byte());
				end else if (j == 7) begin
					send_byte(CH_BSLASH);
					b = any_byte();
					if (b == CH_U)
						b = CH_N;
					send_byte(b);
				end else if (j == 8) begin
					send_byte(CH_QUOTE);
				end else begin
					send_bad_unit();
				end
			end
		end else if (k < 82) begin
			send_bad_unit();
		end else if (k < 92) begin
			send_byte(CH_QUOTE);
		end else begin
			send_byte(any_byte());
		end
	endtask

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		raw_ch.valid = 1'b0;
		raw_ch.in_byte = 8'h00;
		dec_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00);
		send_byte(8'hFF);
		for (int i = 1; i < 5; i++) begin
			send_byte(CH_BSLASH);
			send_byte(simple_esc[i]);
		end
		send_unit(16'hDBFF);
		send_byte(CH_BSLASH);
		send_byte(CH_N);
		send_unit(16'hD800);
		send_byte(CH_QUOTE);
		send_byte(CH_BSLASH);
		send_byte(CH_U);
		send_byte(non_hex_byte());
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pct[p];
			recv_stall_pct = recv_pct[p];
			while (sent < 28 + 125 * (p + 1))
				send_token();
			wait_drained();
		end

		$display("Decoded %0d raw bytes into %0d dec words (%0d string ends, %0d bad escapes),",
			bytes_taken, words_checked, ends_seen, bad_seen);
		$display("with free running, sender idle, receiver stall and mixed pacing.");
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/jsu_pkg.sv
rtl/jsu_if.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/jsu_unescape_checker.sv
tb/json_string_unescape_utf8_tb.sv
